@@ rtl/steq_pkg.sv @@
// ----------------------------------------------------------------------------
// steq_pkg: shared types and codes of the sorted timeout event queue
// Transaction payloads, the queue entry layout, result kinds and the
// sequencer states.
// ----------------------------------------------------------------------------
package steq_pkg;

	// item function codes
	localparam logic FUNC_TICK = 1'b0;
	localparam logic FUNC_ADD  = 1'b1;

	// result kinds
	localparam logic [1:0] KIND_ADD_OK   = 2'd0;
	localparam logic [1:0] KIND_ADD_FULL = 2'd1;
	localparam logic [1:0] KIND_EXPIRED  = 2'd2;

	// tick rate after reset
	localparam logic [31:0] TPS_RESET = 32'd19200000;

	// input transaction
	typedef struct packed {
		logic        func;
		logic [31:0] duration;
		logic [15:0] event_tag;
	} item_t;

	// output transaction
	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] expired_tag;
		logic [31:0] registered_second;
		logic [31:0] expired_duration;
		logic [31:0] now_second;
		logic [4:0]  pending_count;
	} result_t;

	// one stored event
	typedef struct packed {
		logic [31:0] start;
		logic [31:0] length;
		logic [15:0] label;
	} entry_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TICK_CHK,
		ST_SCAN,
		ST_SHIFT,
		ST_INSERT,
		ST_RESULT
	} state_t;

endpackage

@@ rtl/steq_ram.sv @@
// ----------------------------------------------------------------------------
// steq_ram: generic simple dual-port memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module steq_ram #(
	parameter int WIDTH = 80,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

@@ rtl/sorted_timeout_event_queue_core.sv @@
// ----------------------------------------------------------------------------
// sorted_timeout_event_queue_core: deadline-sorted timeout event queue
// Keeps a saturating clock in seconds, advanced by tick transactions, and a
// queue of events sorted by deadline, held as a ring buffer in one memory.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------
//  item    | in        | item_valid/item_stall | item_t (func, duration, tag)
//  result  | out       | result_valid/_stall   | result_t
//  cfg     | in        | cfg_valid/cfg_ready   | ticks_per_second (32 bit)
//
// A tick on an empty queue only advances the clock, else it checks the head
// entry and gives a result on expiry; an expiry only moves the ring head and
// lowers the count. An add scans past the entries whose deadline is not later
// than its own, moves the later entries up, inserts and gives a result; the
// single memory read port serves the scan and shift. A refused add gives its
// result directly. Reset clears the clock, the ring pointers and the count; no
// memory clearing. item is taken only in the idle state; a stalled result waits
// in its output register while the next item is accepted.
// ----------------------------------------------------------------------------
module sorted_timeout_event_queue_core #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  steq_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output steq_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [31:0]       cfg_data
);

	import steq_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int EW = $bits(entry_t);

	state_t state_q, state_nx;

	// clock and configuration
	logic [31:0] tps_q;
	logic [31:0] sub_q;
	logic [31:0] sec_q;

	// ring buffer control
	logic [AW-1:0] hd_q;
	logic [AW-1:0] tl_q;
	logic [CW-1:0] cnt_q;

	// add sequencing
	logic [CW-1:0] k_q;
	logic [AW-1:0] p_q;
	logic [CW-1:0] j_q;
	logic [AW-1:0] ja_q;
	logic [32:0]   dl_q;
	entry_t        new_q;

	// result staging and output register
	result_t res_q;
	result_t out_q;
	logic    out_valid_q;

	// memory ports
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	entry_t        wr_data;
	logic [AW-1:0] rd_addr;
	logic [EW-1:0] rd_raw;
	entry_t        rd_ent;

	// shared deadline compare
	logic [32:0] cmp_lhs;
	logic [32:0] cmp_rhs;
	logic        cmp_le;

	logic        item_acc;
	logic        out_free;
	logic [32:0] sub_nx;
	logic        sec_wrap;
	logic        scan_end;
	logic        q_full;

	// ring index helpers
	function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] x);
		ring_inc = (x == AW'(QUEUE_DEPTH - 1)) ? '0 : x + 1'b1;
	endfunction

	function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] x);
		ring_dec = (x == '0) ? AW'(QUEUE_DEPTH - 1) : x - 1'b1;
	endfunction

	assign item_stall   = (state_q != ST_IDLE);
	assign item_acc     = item_valid && !item_stall;
	assign cfg_ready    = 1'b1;
	assign result_valid = out_valid_q;
	assign result       = out_q;
	assign out_free     = !out_valid_q || !result_stall;
	assign q_full       = (cnt_q == CW'(QUEUE_DEPTH));

	// sub-second counter wrap
	assign sub_nx   = {1'b0, sub_q} + 33'd1;
	assign sec_wrap = (sub_nx >= {1'b0, tps_q});

	// deadline of the entry just read against the current limit
	assign rd_ent  = entry_t'(rd_raw);
	assign cmp_lhs = {1'b0, rd_ent.start} + {1'b0, rd_ent.length};
	assign cmp_rhs = (state_q == ST_TICK_CHK) ? {1'b0, sec_q} : dl_q;
	assign cmp_le  = (cmp_lhs <= cmp_rhs);
	assign scan_end = (k_q == cnt_q) || !cmp_le;

	steq_ram #(
		.WIDTH(EW),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_raw)
	);

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_acc) begin
					if (item.func == FUNC_ADD) begin
						state_nx = q_full ? ST_RESULT : ST_SCAN;
					end else begin
						state_nx = (cnt_q != '0) ? ST_TICK_CHK : ST_IDLE;
					end
				end
			end
			ST_TICK_CHK: begin
				state_nx = cmp_le ? ST_RESULT : ST_IDLE;
			end
			ST_SCAN: begin
				if (k_q == cnt_q) begin
					state_nx = ST_INSERT;
				end else if (!cmp_le) begin
					state_nx = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				if (j_q == k_q) begin
					state_nx = ST_INSERT;
				end
			end
			ST_INSERT: begin
				state_nx = ST_RESULT;
			end
			ST_RESULT: begin
				if (out_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// memory control
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = ja_q;
		wr_data = rd_ent;
		rd_addr = hd_q;
		case (state_q)
			ST_SCAN: begin
				if (k_q != cnt_q && !cmp_le) begin
					rd_addr = ring_dec(tl_q);
				end else begin
					rd_addr = ring_inc(p_q);
				end
			end
			ST_SHIFT: begin
				wr_en   = 1'b1;
				wr_addr = ring_inc(ja_q);
				wr_data = rd_ent;
				rd_addr = ring_dec(ja_q);
			end
			ST_INSERT: begin
				wr_en   = 1'b1;
				wr_addr = p_q;
				wr_data = new_q;
			end
			default: begin
				rd_addr = hd_q;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tps_q       <= TPS_RESET;
			sub_q       <= '0;
			sec_q       <= '0;
			hd_q        <= '0;
			tl_q        <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_valid && cfg_ready) begin
				tps_q <= cfg_data;
			end
			// clock advance on a tick transaction
			if (item_acc && item.func == FUNC_TICK) begin
				if (sec_wrap) begin
					sub_q <= '0;
					if (sec_q != 32'hFFFF_FFFF) begin
						sec_q <= sec_q + 32'd1;
					end
				end else begin
					sub_q <= sub_nx[31:0];
				end
			end
			// head leaves on expiry
			if (state_q == ST_TICK_CHK && cmp_le) begin
				hd_q  <= ring_inc(hd_q);
				cnt_q <= cnt_q - 1'b1;
			end
			// tail grows on insert
			if (state_q == ST_INSERT) begin
				tl_q  <= ring_inc(tl_q);
				cnt_q <= cnt_q + 1'b1;
			end
			// output register
			if (state_q == ST_RESULT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// add datapath and result staging
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (item_acc && item.func == FUNC_ADD) begin
					dl_q         <= {1'b0, sec_q} + {1'b0, item.duration};
					new_q.start  <= sec_q;
					new_q.length <= item.duration;
					new_q.label  <= item.event_tag;
					k_q          <= '0;
					p_q          <= hd_q;
					res_q.kind              <= KIND_ADD_FULL;
					res_q.expired_tag       <= '0;
					res_q.registered_second <= '0;
					res_q.expired_duration  <= '0;
					res_q.now_second        <= sec_q;
					res_q.pending_count     <= 5'(cnt_q);
				end
			end
			ST_TICK_CHK: begin
				res_q.kind              <= KIND_EXPIRED;
				res_q.expired_tag       <= rd_ent.label;
				res_q.registered_second <= rd_ent.start;
				res_q.expired_duration  <= rd_ent.length;
				res_q.now_second        <= sec_q;
				res_q.pending_count     <= 5'(cnt_q - 1'b1);
			end
			ST_SCAN: begin
				if (!scan_end) begin
					k_q <= k_q + 1'b1;
					p_q <= ring_inc(p_q);
				end else if (k_q != cnt_q) begin
					j_q  <= cnt_q - 1'b1;
					ja_q <= ring_dec(tl_q);
				end
			end
			ST_SHIFT: begin
				j_q  <= j_q - 1'b1;
				ja_q <= ring_dec(ja_q);
			end
			ST_INSERT: begin
				res_q.kind              <= KIND_ADD_OK;
				res_q.expired_tag       <= '0;
				res_q.registered_second <= '0;
				res_q.expired_duration  <= '0;
				res_q.now_second        <= sec_q;
				res_q.pending_count     <= 5'(cnt_q + 1'b1);
			end
			ST_RESULT: begin
				if (out_free) begin
					out_q <= res_q;
				end
			end
			default: begin
				k_q <= k_q;
			end
		endcase
	end

endmodule
